FILE: design/mp2d_pkg.sv
// ----------------------------------------------------------------------------
// mp2d_pkg
// Types and constants shared by the 2-D max pooling window unit.
// ----------------------------------------------------------------------------
package mp2d_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 7;

    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_SIZE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIDE      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PADDING     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IN_HEIGHT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IN_WIDTH    = 3'd4;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef struct packed {
        logic               command;
        logic [5:0]         pixel_row;
        logic [5:0]         pixel_col;
        logic signed [15:0] pixel_value;
        logic [5:0]         out_row;
        logic [5:0]         out_col;
    } t_pool_in;

    typedef struct packed {
        logic signed [15:0] max_value;
        logic               window_empty;
        logic               out_of_range;
    } t_pool_out;

endpackage

FILE: design/max_pool_2d_window_unit.sv
// ----------------------------------------------------------------------------
// max_pool_2d_window_unit
// Stores one feature-map plane and returns the maximum of a clipped window.
// ----------------------------------------------------------------------------
// A load transfer writes one pixel into the plane memory in its transfer cycle.
// After a query transfer the input stays stalled while the sequencer steps
// through the row and column offset products, the range check and clipping,
// one memory read per pixel of the clipped window through the single read
// port, the compare of the last read and the hand-over of the result to the
// output register. An empty or rejected window skips the walk and the last
// compare. The hand-over step repeats while an earlier result still waits,
// stalled, in the output register. The read port, walked one pixel a cycle by
// a shared compare unit, sets the query time.
// Queries that touch plane entries never loaded since reset return undefined
// values. The input side stays open for loads while a result waits at the
// output.
module max_pool_2d_window_unit #(
    parameter int MAX_HEIGHT = 64,
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_KERNEL = 8
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  mp2d_pkg::t_pool_in                   i_in_data,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output mp2d_pkg::t_pool_out                  o_out_data,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [mp2d_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [mp2d_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import mp2d_pkg::*;

    localparam int DEPTH = MAX_HEIGHT * MAX_WIDTH;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MUL   = 3'd1;
    localparam logic [2:0] S_CHECK = 3'd2;
    localparam logic [2:0] S_WALK  = 3'd3;
    localparam logic [2:0] S_DRAIN = 3'd4;
    localparam logic [2:0] S_RES   = 3'd5;

    logic [2:0]         r_state;
    logic [3:0]         r_kernel;
    logic [3:0]         r_stride;
    logic [2:0]         r_padding;
    logic [6:0]         r_in_height;
    logic [6:0]         r_in_width;

    logic [15:0]        r_plane [DEPTH];
    logic [15:0]        r_rd_data;
    logic               r_rd_pend;

    logic [5:0]         r_orow;
    logic [5:0]         r_ocol;
    logic [9:0]         r_prod_h;
    logic [9:0]         r_prod_w;
    logic [6:0]         r_hlo;
    logic [6:0]         r_hhi;
    logic [6:0]         r_wlo;
    logic [6:0]         r_whi;
    logic [6:0]         r_r;
    logic [6:0]         r_c;
    logic signed [15:0] r_best;
    logic               r_found;
    logic               r_empty;
    logic               r_oor;

    logic               r_out_valid;
    t_pool_out          r_out_data;

    logic               in_xfer;
    logic               out_free;
    logic               load_ok;
    logic [AW-1:0]      wr_addr;
    logic [AW-1:0]      rd_addr;
    logic               walk_last;

    logic signed [15:0] k_s;
    logic signed [15:0] s_s;
    logic signed [15:0] p_s;
    logic signed [15:0] h_s;
    logic signed [15:0] w_s;
    logic signed [15:0] xh;
    logic signed [15:0] xw;
    logic signed [15:0] hs;
    logic signed [15:0] ws;
    logic signed [15:0] hlo;
    logic signed [15:0] hhi;
    logic signed [15:0] wlo;
    logic signed [15:0] whi;
    logic               row_ok;
    logic               col_ok;
    logic               reject;
    logic               empty;
    logic signed [15:0] rd_s;
    logic               take;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign in_xfer     = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // plane addressing
    assign load_ok = (int'(i_in_data.pixel_row) < MAX_HEIGHT)
                  && (int'(i_in_data.pixel_col) < MAX_WIDTH);
    assign wr_addr = AW'(i_in_data.pixel_row) * AW'(MAX_WIDTH) + AW'(i_in_data.pixel_col);
    assign rd_addr = AW'(r_r) * AW'(MAX_WIDTH) + AW'(r_c);
    assign walk_last = (r_r == r_hhi - 7'd1) && (r_c == r_whi - 7'd1);

    // window check and clipping
    always_comb begin
        k_s = (int'(r_kernel) > MAX_KERNEL) ? 16'(MAX_KERNEL) : 16'(r_kernel);
        s_s = 16'(r_stride);
        p_s = 16'(r_padding);
        h_s = (int'(r_in_height) > MAX_HEIGHT) ? 16'(MAX_HEIGHT) : 16'(r_in_height);
        w_s = (int'(r_in_width) > MAX_WIDTH) ? 16'(MAX_WIDTH) : 16'(r_in_width);
        xh  = h_s + (p_s <<< 1) - k_s;
        xw  = w_s + (p_s <<< 1) - k_s;
        row_ok = (xh >= 16'sd0) ? ($signed({6'd0, r_prod_h}) <= xh)
                                : ((r_orow == 6'd0) && (xh > -s_s));
        col_ok = (xw >= 16'sd0) ? ($signed({6'd0, r_prod_w}) <= xw)
                                : ((r_ocol == 6'd0) && (xw > -s_s));
        reject = (s_s == 16'sd0) || (k_s == 16'sd0) || !row_ok || !col_ok;
        hs  = $signed({6'd0, r_prod_h}) - p_s;
        ws  = $signed({6'd0, r_prod_w}) - p_s;
        hlo = (hs > 16'sd0) ? hs : 16'sd0;
        wlo = (ws > 16'sd0) ? ws : 16'sd0;
        hhi = (hs + k_s < h_s) ? hs + k_s : h_s;
        whi = (ws + k_s < w_s) ? ws + k_s : w_s;
        empty = (hlo >= hhi) || (wlo >= whi);
    end

    assign rd_s = $signed(r_rd_data);
    assign take = !r_found || (rd_s > r_best);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kernel    <= 4'd2;
            r_stride    <= 4'd2;
            r_padding   <= 3'd0;
            r_in_height <= 7'd64;
            r_in_width  <= 7'd64;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_KERNEL_SIZE: r_kernel    <= i_cfg_data[3:0];
                CFG_STRIDE:      r_stride    <= i_cfg_data[3:0];
                CFG_PADDING:     r_padding   <= i_cfg_data[2:0];
                CFG_IN_HEIGHT:   r_in_height <= i_cfg_data;
                CFG_IN_WIDTH:    r_in_width  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // plane memory
    always_ff @(posedge i_clk) begin
        if (in_xfer && (i_in_data.command == CMD_LOAD) && load_ok) begin
            r_plane[wr_addr] <= i_in_data.pixel_value;
        end
        if (r_state == S_WALK) begin
            r_rd_data <= r_plane[rd_addr];
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rd_pend   <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall && (r_state != S_RES)) begin
                r_out_valid <= 1'b0;
            end
            r_rd_pend <= (r_state == S_WALK);
            if (r_rd_pend && take) begin
                r_best  <= rd_s;
                r_found <= 1'b1;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_xfer && (i_in_data.command == CMD_QUERY)) begin
                        r_orow  <= i_in_data.out_row;
                        r_ocol  <= i_in_data.out_col;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod_h <= {4'd0, r_orow} * {6'd0, r_stride};
                    r_prod_w <= {4'd0, r_ocol} * {6'd0, r_stride};
                    r_state  <= S_CHECK;
                end
                S_CHECK: begin
                    r_found <= 1'b0;
                    r_best  <= 16'sd0;
                    r_hlo   <= hlo[6:0];
                    r_hhi   <= hhi[6:0];
                    r_wlo   <= wlo[6:0];
                    r_whi   <= whi[6:0];
                    r_r     <= hlo[6:0];
                    r_c     <= wlo[6:0];
                    r_oor   <= reject;
                    r_empty <= !reject && empty;
                    r_state <= (reject || empty) ? S_RES : S_WALK;
                end
                S_WALK: begin
                    if (r_c == r_whi - 7'd1) begin
                        r_c <= r_wlo;
                        r_r <= r_r + 7'd1;
                    end else begin
                        r_c <= r_c + 7'd1;
                    end
                    if (walk_last) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    r_state <= S_RES;
                end
                S_RES: begin
                    if (out_free) begin
                        r_out_valid             <= 1'b1;
                        r_out_data.max_value    <= r_best;
                        r_out_data.window_empty <= r_empty;
                        r_out_data.out_of_range <= r_oor;
                        r_state                 <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTH
    a_no_pending_read_in_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_rd_pend)
        else $error("read pending while idle");

    a_walk_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> ((r_r < r_hhi) && (r_c < r_whi)
                                 && (r_r >= r_hlo) && (r_c >= r_wlo)))
        else $error("walk left the clipped window");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_data.window_empty && o_out_data.out_of_range))
        else $error("empty and out of range flagged together");

    a_flagged_result_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.window_empty || o_out_data.out_of_range))
        |-> (o_out_data.max_value == 16'sd0))
        else $error("flagged result carries a nonzero value");

    a_walk_result_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_RES) && $past(r_state) == S_DRAIN) |-> r_found)
        else $error("walked window produced no maximum");
`endif

endmodule
